// ===== rtl/g2sf_pkg.sv =====
// g2sf_pkg: shared types and constants for the 2bpp span fill block
// used by g2sf_ctrl, g2sf_dp and gray2bpp_span_fill; no dependencies
package g2sf_pkg;

	localparam int DEF_MAX_SPAN_PIXELS = 240;
	localparam int DEF_PATTERN_ROWS    = 8;

	// magnitude bits walked by the row remainder unit
	localparam int MOD_STEPS = 9;

	localparam logic [1:0]  RST_GRAY_LEVEL     = 2'd3;
	localparam logic        RST_PAINT_MODE     = 1'b1;
	localparam logic [15:0] RST_FRAME_BASE     = 16'd0;
	localparam logic [6:0]  RST_LINE_STRIDE    = 7'd34;
	localparam logic        RST_PATTERN_ON     = 1'b0;
	localparam logic        RST_PATTERN_FIXED  = 1'b0;
	localparam logic [3:0]  RST_PATTERN_HEIGHT = 4'd8;
	localparam logic [63:0] RST_PATTERN_ROWS   = 64'd0;

	typedef enum logic [2:0] {
		REG_GRAY_LEVEL     = 3'd0,
		REG_PAINT_MODE     = 3'd1,
		REG_FRAME_BASE     = 3'd2,
		REG_LINE_STRIDE    = 3'd3,
		REG_PATTERN_ON     = 3'd4,
		REG_PATTERN_FIXED  = 3'd5,
		REG_PATTERN_HEIGHT = 3'd6,
		REG_PATTERN_ROWS   = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MOD  = 4'b0010,
		ST_FIX  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic fix;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic last_byte;
	} dp_status_t;

	typedef struct packed {
		logic [1:0]  gray_level;
		logic        paint_mode;
		logic [15:0] frame_base;
		logic [6:0]  line_stride;
		logic        pattern_on;
		logic        pattern_fixed;
		logic [3:0]  pattern_height;
		logic [63:0] pattern_rows;
	} cfg_t;

endpackage

// ===== rtl/g2sf_ctrl.sv =====
// g2sf_ctrl: sequencer for one span request (prepare, remainder steps, byte loop)
// depends on g2sf_pkg; drives g2sf_dp through dp_cmd_t
module g2sf_ctrl
	import g2sf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t     state_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && (state_q == ST_IDLE);
		cmd.mod_step = (state_q == ST_MOD);
		cmd.fix      = (state_q == ST_FIX);
		cmd.emit     = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !status.len_zero) begin
						state_q <= ST_MOD;
						step_q  <= 4'(MOD_STEPS - 1);
					end
				end
				ST_MOD: begin
					if (step_q == '0) begin
						state_q <= ST_FIX;
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				ST_FIX: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.emit && status.last_byte) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/g2sf_dp.sv =====
// g2sf_dp: span datapath (address, pattern row remainder, rotation, byte masks)
// depends on g2sf_pkg; commanded by g2sf_ctrl
module g2sf_dp
	import g2sf_pkg::*;
#(
	parameter int MAX_SPAN_PIXELS = DEF_MAX_SPAN_PIXELS,
	parameter int PATTERN_ROWS    = DEF_PATTERN_ROWS
) (
	input  logic        clk,
	input  cfg_t        cfg,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [7:0]  span_x,
	input  logic [7:0]  span_y,
	input  logic [7:0]  span_len,
	input  logic [8:0]  origin_x,
	input  logic [8:0]  origin_y,
	output logic [15:0] byte_addr,
	output logic [7:0]  bit_mask,
	output logic [7:0]  bit_value,
	output logic        do_xor,
	output logic        last
);

	localparam int EW = $clog2(255 + MAX_SPAN_PIXELS);
	localparam int BW = EW - 2;

	// request capture
	logic [7:0]    len_sat;
	logic [8:0]    ox_eff;
	logic [8:0]    oy_eff;
	logic [9:0]    diff;
	logic [8:0]    mag;
	logic [EW-1:0] endpx;
	logic [2:0]    phase;
	logic [3:0]    h_clamp;

	logic [BW-1:0] b_q;
	logic [BW-1:0] lastb_q;
	logic [BW-1:0] first_q;
	logic [1:0]    x_lo_q;
	logic [1:0]    end_lo_q;
	logic          pat_en_q;
	logic          neg_q;
	logic [8:0]    mag_q;
	logic [3:0]    rem_q;
	logic [3:0]    h_q;
	logic [2:0]    phase_q;
	logic [14:0]   prod_q;
	logic [15:0]   line_addr_q;
	logic [15:0]   pat_q;

	// remainder step and pattern word
	logic [3:0]  rem_sh;
	logic [3:0]  rem_nxt;
	logic [3:0]  row_full;
	logic [2:0]  row;
	logic [7:0]  row_bits;
	logic [15:0] expanded;
	logic [31:0] rot_dbl;
	logic [3:0]  rot_amt;

	// byte mask
	logic       is_first;
	logic       is_last;
	logic [1:0] lo;
	logic [1:0] hi;
	logic [7:0] mask;

	logic [15:0] addr_q;
	logic [7:0]  mask_q;
	logic [7:0]  value_q;
	logic        xor_q;
	logic        last_q;

	always_comb begin
		len_sat  = (span_len > 8'(MAX_SPAN_PIXELS)) ? 8'(MAX_SPAN_PIXELS) : span_len;
		ox_eff   = cfg.pattern_fixed ? 9'd0 : origin_x;
		oy_eff   = cfg.pattern_fixed ? 9'd0 : origin_y;
		diff     = {2'b00, span_y} - {oy_eff[8], oy_eff};
		mag      = diff[9] ? 9'(-diff) : diff[8:0];
		endpx    = EW'(span_x) + EW'(len_sat) - EW'(1);
		phase    = {span_x[2], 2'b00} - ox_eff[2:0];
		if (cfg.pattern_height == 4'd0) begin
			h_clamp = 4'd1;
		end else if (cfg.pattern_height > 4'(PATTERN_ROWS)) begin
			h_clamp = 4'(PATTERN_ROWS);
		end else begin
			h_clamp = cfg.pattern_height;
		end
	end

	always_comb begin
		rem_sh  = {rem_q[2:0], mag_q[8]};
		rem_nxt = (rem_sh >= h_q) ? rem_sh - h_q : rem_sh;
		row_full = (neg_q && rem_q != 4'd0) ? h_q - rem_q : rem_q;
		row      = row_full[2:0];
		row_bits = cfg.pattern_rows[{row, 3'b000} +: 8];
		for (int i = 0; i < 8; i++) begin
			expanded[2*i +: 2] = {2{row_bits[i]}};
		end
		rot_amt = {phase_q, 1'b0};
		rot_dbl = {expanded, expanded} >> rot_amt;
	end

	always_comb begin
		is_first = (b_q == first_q);
		is_last  = (b_q == lastb_q);
		lo       = is_first ? x_lo_q : 2'd0;
		hi       = is_last ? end_lo_q : 2'd3;
		mask     = (8'hFF << {lo, 1'b0}) & (8'hFF >> (3'd6 - {hi, 1'b0})) & pat_q[7:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q  <= BW'(span_x[7:2]);
			lastb_q  <= endpx[EW-1:2];
			x_lo_q   <= span_x[1:0];
			end_lo_q <= endpx[1:0];
			pat_en_q <= cfg.pattern_on && (origin_x != 9'h1FF);
			neg_q    <= diff[9];
			mag_q    <= mag;
			rem_q    <= 4'd0;
			h_q      <= h_clamp;
			phase_q  <= phase;
			prod_q   <= 15'(span_y * cfg.line_stride);
		end
		if (cmd.mod_step) begin
			rem_q       <= rem_nxt;
			mag_q       <= {mag_q[7:0], 1'b0};
			line_addr_q <= cfg.frame_base + 16'(prod_q);
		end
		if (cmd.fix) begin
			pat_q <= pat_en_q ? rot_dbl[15:0] : 16'hFFFF;
			b_q   <= first_q;
		end
		if (cmd.emit) begin
			addr_q  <= line_addr_q + 16'(b_q);
			mask_q  <= mask;
			value_q <= mask & {4{cfg.gray_level}};
			xor_q   <= ~cfg.paint_mode;
			last_q  <= is_last;
			b_q     <= b_q + BW'(1);
			pat_q   <= {pat_q[7:0], pat_q[15:8]};
		end
	end

	assign status.len_zero  = (span_len == 8'd0);
	assign status.last_byte = is_last;

	assign byte_addr = addr_q;
	assign bit_mask  = mask_q;
	assign bit_value = value_q;
	assign do_xor    = xor_q;
	assign last      = last_q;

endmodule

// ===== rtl/gray2bpp_span_fill.sv =====
// gray2bpp_span_fill: horizontal span fill for a 2bpp framebuffer, top level
// depends on g2sf_pkg, g2sf_ctrl and g2sf_dp; holds the configuration registers
//
// usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one register per
//   transaction; cfg_ready is always high; write only while no span is in flight
//   in channel takes one span request per transaction (span_x, span_y, span_len,
//   origin_x, origin_y); in_ready is high only while the sequencer is idle
//   out channel gives one byte operation per transaction in increasing address
//   order, last marks the final byte of the span; a zero length gives none
//   a taken request is captured, then the bit-serial pattern row remainder is walked
//   and the pattern word set up before the emit loop fills the output register;
//   a span gives up to 61 bytes, one per cycle from the emit loop while the receiver
//   takes them, and a new request is taken only once the last byte has been issued
//   a stalled receiver holds the output register and freezes the byte loop;
//   the next request can be taken while the final byte still waits
//   reset: registers return to their defaults, sequencer idle, out_valid low
module gray2bpp_span_fill
	import g2sf_pkg::*;
#(
	parameter int MAX_SPAN_PIXELS = DEF_MAX_SPAN_PIXELS,
	parameter int PATTERN_ROWS    = DEF_PATTERN_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  span_x,
	input  logic [7:0]  span_y,
	input  logic [7:0]  span_len,
	input  logic [8:0]  origin_x,
	input  logic [8:0]  origin_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] byte_addr,
	output logic [7:0]  bit_mask,
	output logic [7:0]  bit_value,
	output logic        do_xor,
	output logic        last
);

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gray_level     <= RST_GRAY_LEVEL;
			cfg_q.paint_mode     <= RST_PAINT_MODE;
			cfg_q.frame_base     <= RST_FRAME_BASE;
			cfg_q.line_stride    <= RST_LINE_STRIDE;
			cfg_q.pattern_on     <= RST_PATTERN_ON;
			cfg_q.pattern_fixed  <= RST_PATTERN_FIXED;
			cfg_q.pattern_height <= RST_PATTERN_HEIGHT;
			cfg_q.pattern_rows   <= RST_PATTERN_ROWS;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_GRAY_LEVEL:     cfg_q.gray_level     <= cfg_data[1:0];
				REG_PAINT_MODE:     cfg_q.paint_mode     <= cfg_data[0];
				REG_FRAME_BASE:     cfg_q.frame_base     <= cfg_data[15:0];
				REG_LINE_STRIDE:    cfg_q.line_stride    <= cfg_data[6:0];
				REG_PATTERN_ON:     cfg_q.pattern_on     <= cfg_data[0];
				REG_PATTERN_FIXED:  cfg_q.pattern_fixed  <= cfg_data[0];
				REG_PATTERN_HEIGHT: cfg_q.pattern_height <= cfg_data[3:0];
				REG_PATTERN_ROWS:   cfg_q.pattern_rows   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	g2sf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	g2sf_dp #(
		.MAX_SPAN_PIXELS (MAX_SPAN_PIXELS),
		.PATTERN_ROWS    (PATTERN_ROWS)
	) u_dp (
		.clk       (clk),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.status    (status),
		.span_x    (span_x),
		.span_y    (span_y),
		.span_len  (span_len),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.byte_addr (byte_addr),
		.bit_mask  (bit_mask),
		.bit_value (bit_value),
		.do_xor    (do_xor),
		.last      (last)
	);

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for gray2bpp_span_fill, a directed table of
// settings and spans followed by randomized setting phases, all byte ops checked
// depends on g2sf_pkg and gray2bpp_span_fill, needs nothing else
`timescale 1ns / 1ps

module tb_top;
	import g2sf_pkg::*;

	localparam int MAX_PIXELS  = DEF_MAX_SPAN_PIXELS;
	localparam int ROW_COUNT   = DEF_PATTERN_ROWS;
	localparam int SETTLE_CYC  = 24;
	localparam int NPHASES     = 12;
	localparam int PHASE_SPANS = 34;
	localparam int NDIR        = 40;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  mask;
		logic [7:0]  value;
		logic        xo;
		logic        is_last;
	} fill_op_t;

	typedef struct packed {
		logic        is_cfg;
		reg_idx_t    idx;
		logic [63:0] data;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  len;
		logic [8:0]  ox;
		logic [8:0]  oy;
		logic        typed;
		logic [15:0] addr;
		logic [7:0]  mask;
		logic [7:0]  value;
		logic        xo;
	} step_t;

	// typed rows are single-byte spans under the reset settings
	localparam step_t DIR_STEPS [0:NDIR-1] = '{
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd0, 8'd0, 8'd1, 9'h000, 9'h000,
			1'b1, 16'h0000, 8'h03, 8'h03, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd3, 8'd0, 8'd1, 9'h000, 9'h000,
			1'b1, 16'h0000, 8'hC0, 8'hC0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd239, 8'd255, 8'd1, 9'h000, 9'h000,
			1'b1, 16'h2219, 8'hC0, 8'hC0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd1, 8'd1, 8'd2, 9'h000, 9'h000,
			1'b1, 16'h0022, 8'h3C, 8'h3C, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd255, 8'd255, 8'd255, 9'h000, 9'h000, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd0, 8'd7, 8'd240, 9'h000, 9'h000, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd5, 8'd5, 8'd0, 9'h000, 9'h000, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_GRAY_LEVEL, 64'd0, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PAINT_MODE, 64'd0, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_FRAME_BASE, 64'hFFFF, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_LINE_STRIDE, 64'd127, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd2, 8'd255, 8'd13, 9'h000, 9'h000, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_GRAY_LEVEL, 64'd2, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_LINE_STRIDE, 64'd0, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_FRAME_BASE, 64'h1234, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd17, 8'd200, 8'd9, 9'h000, 9'h000, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_GRAY_LEVEL, 64'd1, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PAINT_MODE, 64'd1, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_LINE_STRIDE, 64'd64, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_ROWS, 64'h0F1E_3C78_A55A_C381, '0, '0, '0, '0, '0,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_ON, 64'd1, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_HEIGHT, 64'd3, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd9, 8'd10, 8'd30, 9'h1FF, 9'h003, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd9, 8'd10, 8'd30, 9'h100, 9'h0FF, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd100, 8'd0, 8'd50, 9'h0FF, 9'h100, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd6, 8'd131, 8'd20, 9'h003, 9'h1F5, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_FIXED, 64'd1, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd9, 8'd10, 8'd30, 9'h1FF, 9'h005, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd9, 8'd10, 8'd30, 9'h007, 9'h005, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_HEIGHT, 64'd0, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd33, 8'd77, 8'd40, 9'h002, 9'h009, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_HEIGHT, 64'd15, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_FIXED, 64'd0, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd33, 8'd77, 8'd40, 9'h002, 9'h009, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_HEIGHT, 64'd8, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_ROWS, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, '0, '0,
			1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd0, 8'd255, 8'd240, 9'h1AB, 9'h0C4, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_PATTERN_ROWS, 64'd0, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b1, REG_GRAY_LEVEL, 64'd3, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0, 1'b0},
		'{1'b0, REG_GRAY_LEVEL, 64'd0, 8'd4, 8'd4, 8'd8, 9'h005, 9'h005, 1'b0, '0, '0, '0, 1'b0}
	};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  span_x    = '0;
	logic [7:0]  span_y    = '0;
	logic [7:0]  span_len  = '0;
	logic [8:0]  origin_x  = '0;
	logic [8:0]  origin_y  = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] byte_addr;
	logic [7:0]  bit_mask;
	logic [7:0]  bit_value;
	logic        do_xor;
	logic        last;

	cfg_t     shadow_cfg;
	fill_op_t pending_ops[$];
	logic     no_idle  = 1'b0;
	logic     hold_out = 1'b0;
	int       spans_sent  = 0;
	int       ops_checked = 0;
	int       reg_writes  = 0;
	int       phases      = 0;
	int       err_count   = 0;

	gray2bpp_span_fill DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.span_x    (span_x),
		.span_y    (span_y),
		.span_len  (span_len),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_addr (byte_addr),
		.bit_mask  (bit_mask),
		.bit_value (bit_value),
		.do_xor    (do_xor),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		shadow_cfg.gray_level     = RST_GRAY_LEVEL;
		shadow_cfg.paint_mode     = RST_PAINT_MODE;
		shadow_cfg.frame_base     = RST_FRAME_BASE;
		shadow_cfg.line_stride    = RST_LINE_STRIDE;
		shadow_cfg.pattern_on     = RST_PATTERN_ON;
		shadow_cfg.pattern_fixed  = RST_PATTERN_FIXED;
		shadow_cfg.pattern_height = RST_PATTERN_HEIGHT;
		shadow_cfg.pattern_rows   = RST_PATTERN_ROWS;
	end

	// byte ops of one span under the current settings
	function automatic void predict_span_ops(input logic [7:0] sx, input logic [7:0] sy,
			input logic [7:0] slen, input logic [8:0] ox, input logic [8:0] oy);
		int unsigned npx, end_px, b_first, b_last, lo, hi, rot;
		int          h, org_x, org_y, row;
		logic [15:0] pat, word, row_addr;
		logic [7:0]  pat_line, gray4, mask;
		fill_op_t    op;
		if (slen == 8'd0)
			return;
		npx = (slen > MAX_PIXELS) ? MAX_PIXELS : slen;
		pat = 16'hFFFF;
		if (shadow_cfg.pattern_on && ox != 9'h1FF) begin
			h = shadow_cfg.pattern_height;
			if (h < 1)
				h = 1;
			if (h > ROW_COUNT)
				h = ROW_COUNT;
			org_x = int'($signed(ox));
			org_y = int'($signed(oy));
			if (shadow_cfg.pattern_fixed) begin
				org_x = 0;
				org_y = 0;
			end
			row = (int'(sy) - org_y) % h;
			if (row < 0)
				row += h;
			pat_line = shadow_cfg.pattern_rows[8*row +: 8];
			word = '0;
			for (int i = 0; i < 8; i++)
				word[2*i +: 2] = {2{pat_line[i]}};
			rot = 2 * (((int'(sx) & ~3) - org_x) & 7);
			pat = 16'({word, word} >> rot);
		end
		end_px   = sx + npx - 1;
		b_first  = sx >> 2;
		b_last   = end_px >> 2;
		row_addr = shadow_cfg.frame_base + shadow_cfg.line_stride * sy;
		gray4    = {4{shadow_cfg.gray_level}};
		for (int unsigned b = b_first; b <= b_last; b++) begin
			lo = (b == b_first) ? sx[1:0] : 0;
			hi = (b == b_last) ? (end_px & 3) : 3;
			mask = (8'hFF << (2 * lo)) & (8'hFF >> (6 - 2 * hi));
			mask &= pat[7:0];
			op.addr    = row_addr + 16'(b);
			op.mask    = mask;
			op.value   = mask & gray4;
			op.xo      = ~shadow_cfg.paint_mode;
			op.is_last = (b == b_last);
			pending_ops.push_back(op);
			pat = {pat[7:0], pat[15:8]};
		end
	endfunction

	task automatic write_setting(input reg_idx_t idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
		case (idx)
			REG_GRAY_LEVEL:     shadow_cfg.gray_level     = data[1:0];
			REG_PAINT_MODE:     shadow_cfg.paint_mode     = data[0];
			REG_FRAME_BASE:     shadow_cfg.frame_base     = data[15:0];
			REG_LINE_STRIDE:    shadow_cfg.line_stride    = data[6:0];
			REG_PATTERN_ON:     shadow_cfg.pattern_on     = data[0];
			REG_PATTERN_FIXED:  shadow_cfg.pattern_fixed  = data[0];
			REG_PATTERN_HEIGHT: shadow_cfg.pattern_height = data[3:0];
			REG_PATTERN_ROWS:   shadow_cfg.pattern_rows   = data;
			default: ;
		endcase
	endtask

	// drain: wait until no byte ops are expected; zero-length spans keep the block idle
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_ops.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic offer_span(input logic [7:0] sx, input logic [7:0] sy,
			input logic [7:0] slen, input logic [8:0] ox, input logic [8:0] oy,
			input logic typed, input fill_op_t typed_op);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		span_x   <= sx;
		span_y   <= sy;
		span_len <= slen;
		origin_x <= ox;
		origin_y <= oy;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		if (typed)
			pending_ops.push_back(typed_op);
		else
			predict_span_ops(sx, sy, slen, ox, oy);
		spans_sent++;
	endtask

	task automatic random_span();
		logic [7:0] sx, sy, slen;
		logic [8:0] ox, oy;
		sx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 239));
		sy = 8'($urandom);
		case ($urandom_range(0, 19))
			0:          slen = 8'd0;
			1:          slen = 8'($urandom_range(241, 255));
			2, 3, 4, 5: slen = 8'($urandom_range(17, 240));
			default:    slen = 8'($urandom_range(1, 16));
		endcase
		ox = ($urandom_range(0, 3) == 0) ? 9'h1FF : 9'($urandom);
		oy = 9'($urandom);
		offer_span(sx, sy, slen, ox, oy, 1'b0, '0);
	endtask

	task automatic random_settings();
		logic [15:0] base;
		logic [6:0]  stride;
		logic [3:0]  height;
		logic [63:0] rows;
		case ($urandom_range(0, 3))
			0:       base = 16'h0000;
			1:       base = 16'hFFFF;
			default: base = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0:       stride = 7'd1;
			1:       stride = 7'd64;
			2:       stride = $urandom_range(0, 1) ? 7'd127 : 7'd0;
			default: stride = 7'($urandom_range(1, 64));
		endcase
		height = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		case ($urandom_range(0, 5))
			0:       rows = '1;
			1:       rows = '0;
			default: rows = {$urandom, $urandom};
		endcase
		write_setting(REG_GRAY_LEVEL, 64'($urandom_range(0, 3)));
		write_setting(REG_PAINT_MODE, 64'($urandom_range(0, 1)));
		write_setting(REG_FRAME_BASE, 64'(base));
		write_setting(REG_LINE_STRIDE, 64'(stride));
		write_setting(REG_PATTERN_ON, ($urandom_range(0, 3) != 0) ? 64'd1 : 64'd0);
		write_setting(REG_PATTERN_FIXED, 64'($urandom_range(0, 1)));
		write_setting(REG_PATTERN_HEIGHT, 64'(height));
		write_setting(REG_PATTERN_ROWS, rows);
	endtask

	task automatic log_mismatch(input string what, input fill_op_t want, input fill_op_t got);
		if (err_count < 10)
			$display({"%0t %s: expected addr %h mask %h value %h xor %b last %b, ",
				"got addr %h mask %h value %h xor %b last %b"},
				$time, what, want.addr, want.mask, want.value, want.xo, want.is_last,
				got.addr, got.mask, got.value, got.xo, got.is_last);
		err_count++;
	endtask

	// receiver
	initial begin
		int w;
		wait (arst_n);
		@(posedge clk);
		forever begin
			w = no_idle ? 0 : $urandom_range(0, 5);
			if (w > 0 || hold_out) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
				while (hold_out)
					@(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	// long output stall while spans keep coming
	initial begin
		wait (spans_sent >= 150);
		@(negedge clk);
		hold_out = 1'b1;
		repeat (300) @(negedge clk);
		hold_out = 1'b0;
	end

	always @(negedge clk) begin : byte_op_check
		fill_op_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {byte_addr, bit_mask, bit_value, do_xor, last};
			if (pending_ops.size() == 0) begin
				log_mismatch("unexpected transaction", '0, got);
			end else begin
				want = pending_ops.pop_front();
				ops_checked++;
				if (got !== want)
					log_mismatch("byte op mismatch", want, got);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("timeout with %0d byte ops outstanding", pending_ops.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		step_t s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NDIR; i++) begin
			s = DIR_STEPS[i];
			if (s.is_cfg) begin
				settle();
				write_setting(s.idx, s.data);
			end else begin
				offer_span(s.x, s.y, s.len, s.ox, s.oy, s.typed,
					{s.addr, s.mask, s.value, s.xo, 1'b1});
			end
		end
		for (int p = 0; p < NPHASES; p++) begin
			settle();
			no_idle <= (p % 4 == 3);
			random_settings();
			phases++;
			repeat (PHASE_SPANS) random_span();
		end
		settle();
		$display("%0d spans over the directed table and %0d random setting phases, %0d byte ops checked",
			spans_sent, phases, ops_checked);
		$display("%0d register writes, solid and pattern fills, paint and xor, %0d mismatches",
			reg_writes, err_count);
		if (err_count == 0 && pending_ops.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
